// File: rtl/crr_pkg.sv
// Shared constants and types for the context residual refiner.
`default_nettype none

package crr_pkg;

	localparam int MAX_WIDTH_DEF     = 4096;
	localparam int RESIDUAL_BITS_DEF = 16;
	localparam int CTX_BITS          = 16;
	localparam int ROW_BITS          = 16;
	localparam int CNT_W             = 4;
	localparam int IMG_W_BITS        = 13;
	localparam int MIN_WIDTH         = 5;
	localparam int AVG_LIMIT         = 3;
	localparam int MIN_MATCH         = 2;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0]  CFG_REFINE_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0]  CFG_IMAGE_WIDTH = 1'd1;
	localparam logic                  REFINE_MODE_RST = 1'b1;
	localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RST = 13'd1024;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_EVAL,
		ST_DIV,
		ST_OUT
	} crr_state_t;

	// line buffer neighbours, in read order
	typedef enum logic [2:0] {
		NB_N,
		NB_NW,
		NB_NWW,
		NB_NE,
		NB_NEE,
		NB_NN
	} crr_nbr_t;

	typedef struct packed {
		logic busy;
		logic done;
	} crr_div_stat_t;

endpackage

`default_nettype wire

// File: rtl/crr_line_buf.sv
// Two-row line buffer: one write port, one registered read port.
`default_nettype none

module crr_line_buf
	import crr_pkg::*;
#(
	parameter int DEPTH = 2 * MAX_WIDTH_DEF,
	parameter int DW    = RESIDUAL_BITS_DEF + CTX_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [DW-1:0]            wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [DW-1:0]            rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/crr_div.sv
// Serial signed divider of the neighbour sum by the match count, truncating toward zero.
`default_nettype none

module crr_div
	import crr_pkg::*;
#(
	parameter int SUM_W = RESIDUAL_BITS_DEF + 3
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [SUM_W-1:0] dividend,
	input  wire logic [CNT_W-1:0]        divisor,
	output crr_div_stat_t                stat,
	output logic signed [SUM_W-1:0]      quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]        mag_q;
	logic [CNT_W-1:0]        rem_q;
	logic [CNT_W-1:0]        dvs_q;
	logic                    neg_q;
	logic [STEP_W-1:0]       step_q;
	logic                    busy_q;
	logic                    done_q;
	logic signed [SUM_W-1:0] quo_q;
	logic [CNT_W:0]          trial;
	logic                    fits;

	assign trial = {rem_q, mag_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				if (step_q != '0) begin
					step_q <= step_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division on the magnitude, sign applied in the last cycle
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[SUM_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
			rem_q <= '0;
			neg_q <= dividend[SUM_W-1];
			dvs_q <= divisor;
		end else if (busy_q && step_q != '0) begin
			mag_q <= {mag_q[SUM_W-2:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
		end else if (busy_q) begin
			quo_q <= neg_q ? -$signed(mag_q) : $signed(mag_q);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

// File: rtl/context_residual_refiner.sv
// Context residual refiner top level: sequencer, neighbour accumulation and output stage.
`default_nettype none

// Refines a raster stream of residuals using the eight causal neighbours that share the
// pixel's context. One pixel is processed at a time. A border pixel passes from acceptance
// through the write, evaluate and output states to the output register. An interior pixel
// reads its six line-buffer neighbours one per cycle through the single read port of the
// line buffer, then writes itself back. When two or fewer neighbours match, the divider is
// skipped; otherwise the average is formed by the serial divider, which retires one
// quotient bit per cycle. A finished result waits in the output register while the next
// pixel is taken. Configuration writes are accepted in every cycle.
module context_residual_refiner
	import crr_pkg::*;
#(
	parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
	parameter int RESIDUAL_BITS = RESIDUAL_BITS_DEF
) (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             cfg_valid,
	output logic                                                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]                             cfg_index,
	input  wire logic [CFG_DATA_W-1:0]                            cfg_data,
	input  wire logic                                             s_axis_tvalid,
	output logic                                                  s_axis_tready,
	// residual, context_id
	input  wire logic [((RESIDUAL_BITS+CTX_BITS+7)/8)*8-1:0] s_axis_tdata,
	// frame_start
	input  wire logic                                             s_axis_tuser,
	output logic                                                  m_axis_tvalid,
	input  wire logic                                             m_axis_tready,
	// refined_residual
	output logic [((RESIDUAL_BITS+1+7)/8)*8-1:0]                  m_axis_tdata,
	// was_adjusted
	output logic                                                  m_axis_tuser
);

	localparam int RB = RESIDUAL_BITS;
	localparam int OB = RB + 1;
	localparam int SW = RB + 3;
	localparam int OW = ((RB + 1 + 7) / 8) * 8;
	localparam int CB = $clog2(MAX_WIDTH);
	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int AW = $clog2(2 * MAX_WIDTH);
	localparam int DW = RB + CTX_BITS;
	localparam int XW = (IMG_W_BITS > WB) ? IMG_W_BITS : WB;

	localparam logic signed [SW-1:0] AVG_HI = SW'(AVG_LIMIT);
	localparam logic signed [SW-1:0] AVG_LO = -AVG_HI;

	crr_state_t state_q, state_d;

	logic                  mode_q;
	logic [IMG_W_BITS-1:0] image_width_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [CB-1:0]         col_q;
	logic [RB-1:0]         w_res_q, ww_res_q;
	logic [CTX_BITS-1:0]   w_ctx_q, ww_ctx_q;

	logic [RB-1:0]         item_res_q;
	logic [CTX_BITS-1:0]   item_ctx_q;
	logic [CB-1:0]         item_col_q;
	logic                  item_par_q;
	logic                  interior_q;
	logic signed [SW-1:0]  sum_q;
	logic [CNT_W-1:0]      cnt_q;
	crr_nbr_t              rd_sel_q;
	logic                  rd_vld_s1;
	logic signed [SW-1:0]  avg_q;
	logic                  use_avg_q;

	logic                  m_valid_q;
	logic [OB-1:0]         refined_q;
	logic                  adj_q;

	logic [RB-1:0]         in_res;
	logic [CTX_BITS-1:0]   in_ctx;
	logic [XW-1:0]         img_w_x;
	logic [WB-1:0]         eff_width;
	logic [ROW_BITS-1:0]   cur_row;
	logic [CB-1:0]         cur_col;
	logic [WB:0]           cur_col_x;
	logic                  accept;
	logic                  interior_now;
	logic                  match_w, match_ww;
	logic signed [SW-1:0]  sum_init;
	logic [CNT_W-1:0]      cnt_init;

	logic [CB-1:0]         nb_col;
	logic                  nb_par;
	logic [AW-1:0]         lb_rd_addr, lb_wr_addr;
	logic [DW-1:0]         lb_rd_data;
	logic                  lb_rd_en, lb_wr_en;
	logic [RB-1:0]         rd_res;
	logic [CTX_BITS-1:0]   rd_ctx;

	logic                  do_div;
	logic                  div_start;
	crr_div_stat_t         div_stat;
	logic signed [SW-1:0]  div_quo;
	logic                  out_load;

	logic signed [SW-1:0]  half_sum;
	logic signed [SW-1:0]  half;
	logic signed [OB-1:0]  half_r;
	logic signed [OB-1:0]  res_x;
	logic signed [OB-1:0]  val;
	logic                  adj_d;
	logic [OB-1:0]         refined_d;

	assign in_res = s_axis_tdata[RB-1:0];
	assign in_ctx = s_axis_tdata[RB+CTX_BITS-1:RB];

	// width register clamped to the supported range
	assign img_w_x = XW'(image_width_q);
	always_comb begin
		if (img_w_x < XW'(MIN_WIDTH)) begin
			eff_width = WB'(MIN_WIDTH);
		end else if (img_w_x > XW'(MAX_WIDTH)) begin
			eff_width = WB'(MAX_WIDTH);
		end else begin
			eff_width = WB'(img_w_x);
		end
	end

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign cur_row   = s_axis_tuser ? '0 : row_q;
	assign cur_col   = s_axis_tuser ? '0 : col_q;
	assign cur_col_x = (WB+1)'(cur_col);

	assign interior_now = (|cur_row[ROW_BITS-1:1]) && (cur_col_x >= (WB+1)'(2)) &&
		(cur_col_x + (WB+1)'(2) < (WB+1)'(eff_width));

	assign match_w  = w_ctx_q == in_ctx;
	assign match_ww = ww_ctx_q == in_ctx;
	assign sum_init = (match_w ? SW'($signed(w_res_q)) : SW'(0)) +
		(match_ww ? SW'($signed(ww_res_q)) : SW'(0));
	assign cnt_init = CNT_W'(match_w) + CNT_W'(match_ww);

	// neighbour address: N row is the other parity, NN shares this row's parity
	always_comb begin
		nb_par = ~item_par_q;
		case (rd_sel_q)
			NB_N:    nb_col = item_col_q;
			NB_NW:   nb_col = item_col_q - CB'(1);
			NB_NWW:  nb_col = item_col_q - CB'(2);
			NB_NE:   nb_col = item_col_q + CB'(1);
			NB_NEE:  nb_col = item_col_q + CB'(2);
			NB_NN: begin
				nb_col = item_col_q;
				nb_par = item_par_q;
			end
			default: nb_col = item_col_q;
		endcase
	end

	assign lb_rd_addr = (nb_par ? AW'(MAX_WIDTH) : AW'(0)) + AW'(nb_col);
	assign lb_wr_addr = (item_par_q ? AW'(MAX_WIDTH) : AW'(0)) + AW'(item_col_q);
	assign rd_res     = lb_rd_data[RB-1:0];
	assign rd_ctx     = lb_rd_data[DW-1:RB];

	crr_line_buf #(
		.DEPTH (2 * MAX_WIDTH),
		.DW    (DW)
	) u_line_buf (
		.clk     (clk),
		.wr_en   (lb_wr_en),
		.wr_addr (lb_wr_addr),
		.wr_data ({item_ctx_q, item_res_q}),
		.rd_en   (lb_rd_en),
		.rd_addr (lb_rd_addr),
		.rd_data (lb_rd_data)
	);

	assign do_div = interior_q && (cnt_q > CNT_W'(MIN_MATCH));

	crr_div #(
		.SUM_W (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = interior_now ? ST_READ : ST_WRITE;
				end
			end
			ST_READ: begin
				if (rd_sel_q == NB_NN) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_EVAL;
			ST_EVAL:  state_d = do_div ? ST_DIV : ST_OUT;
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = state_q == ST_IDLE;
		lb_rd_en      = state_q == ST_READ;
		lb_wr_en      = state_q == ST_WRITE;
		div_start     = (state_q == ST_EVAL) && do_div;
		out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
	end

	// correction
	assign half_sum  = avg_q + SW'($signed({1'b0, avg_q[SW-1]}));
	assign half      = half_sum >>> 1;
	assign half_r    = OB'(half);
	assign res_x     = OB'($signed(item_res_q));
	assign val       = mode_q ? res_x - half_r : res_x + half_r;
	assign adj_d     = use_avg_q && ((avg_q > AVG_HI) || (avg_q < AVG_LO));
	assign refined_d = adj_d ? $unsigned(val) : $unsigned(res_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= REFINE_MODE_RST;
			image_width_q <= IMAGE_WIDTH_RST;
			row_q         <= '0;
			col_q         <= '0;
			w_res_q       <= '0;
			ww_res_q      <= '0;
			w_ctx_q       <= '0;
			ww_ctx_q      <= '0;
			rd_sel_q      <= NB_N;
			rd_vld_s1     <= 1'b0;
			use_avg_q     <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= lb_rd_en;

			if (cfg_valid) begin
				case (cfg_index)
					CFG_REFINE_MODE: mode_q <= cfg_data[0];
					CFG_IMAGE_WIDTH: image_width_q <= cfg_data[IMG_W_BITS-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				w_res_q  <= in_res;
				ww_res_q <= w_res_q;
				w_ctx_q  <= in_ctx;
				ww_ctx_q <= w_ctx_q;
				rd_sel_q <= NB_N;
				use_avg_q <= 1'b0;
				if (cur_col_x + (WB+1)'(1) >= (WB+1)'(eff_width)) begin
					col_q <= '0;
					row_q <= (&cur_row) ? cur_row : cur_row + 1'b1;
				end else begin
					col_q <= cur_col + CB'(1);
					row_q <= cur_row;
				end
			end else if (lb_rd_en) begin
				rd_sel_q <= crr_nbr_t'(rd_sel_q + 1'b1);
			end

			if (div_stat.done) begin
				use_avg_q <= 1'b1;
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_res_q <= in_res;
			item_ctx_q <= in_ctx;
			item_col_q <= cur_col;
			item_par_q <= cur_row[0];
			interior_q <= interior_now;
			sum_q      <= sum_init;
			cnt_q      <= cnt_init;
		end else if (rd_vld_s1 && rd_ctx == item_ctx_q) begin
			sum_q <= sum_q + SW'($signed(rd_res));
			cnt_q <= cnt_q + 1'b1;
		end
		if (div_stat.done) begin
			avg_q <= div_quo;
		end
		if (out_load) begin
			refined_q <= refined_d;
			adj_q     <= adj_d;
		end
	end

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OW'(refined_q);
	assign m_axis_tuser  = adj_q;

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == ST_DIV)
		else $error("divider running outside its state");

	a_read_only_interior: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> interior_q)
		else $error("neighbour read for a border pixel");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("second transaction taken while a pixel is in flight");

	a_rw_order: assert property (@(posedge clk) disable iff (!arst_n)
		lb_wr_en |-> !lb_rd_en && $past(state_q) != ST_WRITE)
		else $error("line buffer written out of order");

endmodule

`default_nettype wire
